FILE: rtl/prrf_pkg.sv
// ----------------------------------------------------------------------------
// Packet record ring FIFO package
// Shared sizes, command and status codes, and the control and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package prrf_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_TOO_BIG  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BYTE     = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic do_begin;
        logic do_wr_len;
        logic do_data;
        logic do_empty;
        logic do_rd_hdr;
        logic do_rd_next;
        logic do_hdr_port;
        logic do_hdr_len;
        logic do_rd_data;
    } ctl_t;

    typedef struct packed {
        logic out_free;
        logic begin_ok;
        logic ring_empty;
        logic rd_in_record;
        logic hdr_len_zero;
    } sts_t;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: rtl/prrf_ctrl.sv
// ----------------------------------------------------------------------------
// Packet record ring FIFO controller
// Sequences each command through the write and read steps of the datapath.
// ----------------------------------------------------------------------------
module prrf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [1:0]         in_command,
    output logic               in_ready,
    input  prrf_pkg::sts_t     sts,
    output prrf_pkg::ctl_t     ctl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WLEN = 5'b00010,
        S_RHP  = 5'b00100,
        S_RHL  = 5'b01000,
        S_RDAT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   fire;

    assign in_ready = (state_reg == S_IDLE) && sts.out_free;
    assign fire     = in_valid && in_ready;

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (fire) begin
                    if (in_command == prrf_pkg::CMD_BEGIN) begin
                        ctl.do_begin = 1'b1;
                        if (sts.begin_ok) begin
                            state_next = S_WLEN;
                        end
                    end else if (in_command == prrf_pkg::CMD_DATA) begin
                        ctl.do_data = 1'b1;
                    end else if (sts.rd_in_record) begin
                        ctl.do_rd_next = 1'b1;
                        state_next     = S_RDAT;
                    end else if (sts.ring_empty) begin
                        ctl.do_empty = 1'b1;
                    end else begin
                        ctl.do_rd_hdr = 1'b1;
                        state_next    = S_RHP;
                    end
                end
            end
            S_WLEN: begin
                ctl.do_wr_len = 1'b1;
                state_next    = S_IDLE;
            end
            S_RHP: begin
                ctl.do_hdr_port = 1'b1;
                state_next      = S_RHL;
            end
            S_RHL: begin
                ctl.do_hdr_len = 1'b1;
                state_next     = sts.hdr_len_zero ? S_IDLE : S_RDAT;
            end
            S_RDAT: begin
                ctl.do_rd_data = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/prrf_datapath.sv
// ----------------------------------------------------------------------------
// Packet record ring FIFO datapath
// Byte ring memory, write and read pointers, packet counters, header latches
// and the result register.
// ----------------------------------------------------------------------------
module prrf_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  prrf_pkg::ctl_t     ctl,
    output prrf_pkg::sts_t     sts,
    input  logic [7:0]         in_port,
    input  logic [15:0]        in_length,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_status,
    output logic [7:0]         out_port,
    output logic [7:0]         out_length,
    output logic [7:0]         out_data,
    output logic               out_last
);

    logic [7:0] ring [prrf_pkg::RING_DEPTH];

    logic [prrf_pkg::PTR_W-1:0] wp_reg, wp_next;
    logic [prrf_pkg::PTR_W-1:0] cwp_reg, cwp_next;
    logic [prrf_pkg::PTR_W-1:0] rp_reg, rp_next;
    logic [7:0] wbl_reg, wbl_next;
    logic       wa_reg, wa_next;
    logic [7:0] rbl_reg, rbl_next;
    logic       rir_reg, rir_next;
    logic [7:0] port_latch_reg, port_latch_next;
    logic [7:0] len_latch_reg, len_latch_next;
    logic [7:0] len_hold_reg, len_hold_next;
    logic [7:0] rdata_reg;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_status_reg, out_status_next;
    logic [7:0] out_port_reg, out_port_next;
    logic [7:0] out_length_reg, out_length_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;
    logic       out_load;

    logic                       wr_en;
    logic [prrf_pkg::PTR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       rd_en;

    logic [prrf_pkg::CNT_W-1:0] used;
    logic [prrf_pkg::CNT_W-1:0] room;
    logic [prrf_pkg::CNT_W-1:0] need;
    logic                       too_big;
    logic                       full;
    logic [7:0]                 rbl_dec;

    always_comb begin
        if (cwp_reg >= rp_reg) begin
            used = prrf_pkg::CNT_W'(cwp_reg) - prrf_pkg::CNT_W'(rp_reg);
        end else begin
            used = prrf_pkg::CNT_W'(cwp_reg) + prrf_pkg::CNT_W'(prrf_pkg::RING_DEPTH)
                   - prrf_pkg::CNT_W'(rp_reg);
        end
        room    = prrf_pkg::CNT_W'(prrf_pkg::RING_DEPTH) - used;
        need    = prrf_pkg::CNT_W'(in_length[7:0]) + prrf_pkg::CNT_W'(3);
        too_big = (in_length[15:8] != 8'd0);
        full    = (room < need);
        rbl_dec = rbl_reg - 8'd1;
    end

    assign sts.out_free     = !out_valid_reg || out_ready;
    assign sts.begin_ok     = !too_big && !full;
    assign sts.ring_empty   = (cwp_reg == rp_reg);
    assign sts.rd_in_record = rir_reg;
    assign sts.hdr_len_zero = (rdata_reg == 8'd0);

    always_comb begin
        wp_next         = wp_reg;
        cwp_next        = cwp_reg;
        rp_next         = rp_reg;
        wbl_next        = wbl_reg;
        wa_next         = wa_reg;
        rbl_next        = rbl_reg;
        rir_next        = rir_reg;
        port_latch_next = port_latch_reg;
        len_latch_next  = len_latch_reg;
        len_hold_next   = len_hold_reg;
        wr_en           = 1'b0;
        wr_addr         = wp_reg;
        wr_data         = in_byte;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_port_next   = 8'd0;
        out_length_next = 8'd0;
        out_data_next   = 8'd0;
        out_last_next   = 1'b0;

        rd_en = ctl.do_rd_hdr || ctl.do_rd_next || ctl.do_hdr_port
                || (ctl.do_hdr_len && !sts.hdr_len_zero);
        if (rd_en) begin
            rp_next = prrf_pkg::adv(rp_reg);
        end

        if (ctl.do_begin) begin
            wa_next  = 1'b0;
            wbl_next = 8'd0;
            out_load = 1'b1;
            if (too_big) begin
                wp_next         = cwp_reg;
                out_status_next = prrf_pkg::ST_TOO_BIG;
            end else if (full) begin
                wp_next         = cwp_reg;
                out_status_next = prrf_pkg::ST_FULL;
            end else begin
                wr_en           = 1'b1;
                wr_addr         = cwp_reg;
                wr_data         = in_port;
                wp_next         = prrf_pkg::adv(cwp_reg);
                len_hold_next   = in_length[7:0];
                out_status_next = prrf_pkg::ST_ACCEPTED;
            end
        end

        if (ctl.do_wr_len) begin
            wr_en   = 1'b1;
            wr_data = len_hold_reg;
            wp_next = prrf_pkg::adv(wp_reg);
            if (len_hold_reg == 8'd0) begin
                cwp_next = prrf_pkg::adv(wp_reg);
            end else begin
                wbl_next = len_hold_reg;
                wa_next  = 1'b1;
            end
        end

        if (ctl.do_data) begin
            out_load        = 1'b1;
            out_status_next = prrf_pkg::ST_BYTE;
            if (wa_reg && (wbl_reg != 8'd0)) begin
                wr_en    = 1'b1;
                wp_next  = prrf_pkg::adv(wp_reg);
                wbl_next = wbl_reg - 8'd1;
                if (wbl_reg == 8'd1) begin
                    cwp_next = prrf_pkg::adv(wp_reg);
                    wa_next  = 1'b0;
                end
            end
        end

        if (ctl.do_empty) begin
            out_load        = 1'b1;
            out_status_next = prrf_pkg::ST_EMPTY;
        end

        if (ctl.do_hdr_port) begin
            port_latch_next = rdata_reg;
        end

        if (ctl.do_hdr_len) begin
            len_latch_next = rdata_reg;
            rbl_next       = rdata_reg;
            if (sts.hdr_len_zero) begin
                out_load        = 1'b1;
                out_status_next = prrf_pkg::ST_READ;
                out_port_next   = port_latch_reg;
                out_length_next = rdata_reg;
                out_last_next   = 1'b1;
            end
        end

        if (ctl.do_rd_data) begin
            rbl_next        = rbl_dec;
            rir_next        = (rbl_dec != 8'd0);
            out_load        = 1'b1;
            out_status_next = prrf_pkg::ST_READ;
            out_port_next   = port_latch_reg;
            out_length_next = len_latch_reg;
            out_data_next   = rdata_reg;
            out_last_next   = (rbl_dec == 8'd0);
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= ring[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            cwp_reg        <= '0;
            rp_reg         <= '0;
            wbl_reg        <= 8'd0;
            wa_reg         <= 1'b0;
            rbl_reg        <= 8'd0;
            rir_reg        <= 1'b0;
            port_latch_reg <= 8'd0;
            len_latch_reg  <= 8'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            wp_reg         <= wp_next;
            cwp_reg        <= cwp_next;
            rp_reg         <= rp_next;
            wbl_reg        <= wbl_next;
            wa_reg         <= wa_next;
            rbl_reg        <= rbl_next;
            rir_reg        <= rir_next;
            port_latch_reg <= port_latch_next;
            len_latch_reg  <= len_latch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_hold_reg <= len_hold_next;
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_port_reg   <= out_port_next;
            out_length_reg <= out_length_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_port   = out_port_reg;
    assign out_length = out_length_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;

    a_open_packet_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        wa_reg |-> (wbl_reg != 8'd0))
        else $error("Open packet has no bytes left to write.");

    a_open_record_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        rir_reg |-> (rbl_reg != 8'd0))
        else $error("Open record has no bytes left to read.");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("A pending result was overwritten.");

endmodule

FILE: rtl/packet_record_ring_fifo.sv
// ----------------------------------------------------------------------------
// Packet record ring FIFO
// Stores length-prefixed packet records in a byte ring and returns them one
// data byte per read command, with one result transfer per command.
// ----------------------------------------------------------------------------
// A command transfer is taken only while the block is between commands and
// its result register is empty or being drained. A data command, a refused
// begin command or a read of an empty ring needs no further step; an accepted
// begin then writes the length byte, a read inside a record returns the data
// byte fetched, and a read that starts a record first fetches the port and
// length bytes (and no data byte for a zero-length record). The ring memory
// has a single write port and a single registered read port and moves one
// header or data byte per cycle; it needs no initialization pass after reset.
module packet_record_ring_fifo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] port_number, [23:8] packet_length, [31:24] data_byte
    input  logic [31:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_port, [15:8] out_length, [23:16] out_data
    output logic [23:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    prrf_pkg::ctl_t ctl;
    prrf_pkg::sts_t sts;

    logic [7:0] out_port;
    logic [7:0] out_length;
    logic [7:0] out_data;

    prrf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (s_tready),
        .sts        (sts),
        .ctl        (ctl)
    );

    prrf_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .in_port    (s_tdata[7:0]),
        .in_length  (s_tdata[23:8]),
        .in_byte    (s_tdata[31:24]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_port   (out_port),
        .out_length (out_length),
        .out_data   (out_data),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_data, out_length, out_port};

endmodule
